/* rtl/core/dop_pkg.sv */
// ----------------------------------------------------------------------------
// DHCP option parser package
// Shared constants, codes and the queue entry type used by the front end,
// the back end and the top level of the DHCP option parser.
// ----------------------------------------------------------------------------
package dop_pkg;

   // Largest client identifier that the block can hold, in bytes.
   localparam int CLIENT_ID_MAX_BYTES = 16;

   // Depth of the queue between the front and back ends.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLIENT_ID_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLIENT_ID_LOW    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLIENT_ID_HIGH   = 2'd2;
   localparam int CSR_DATA_W = 64;
   localparam int ID_LENGTH_W = 5;

   // Magic cookie, first byte in entry 0.
   localparam logic [3:0][7:0] MAGIC_COOKIE = {8'd99, 8'd83, 8'd130, 8'd99};

   // Option codes of interest.
   localparam logic [7:0] OPT_PAD          = 8'd0;
   localparam logic [7:0] OPT_LEASE_TIME   = 8'd51;
   localparam logic [7:0] OPT_MESSAGE_TYPE = 8'd53;
   localparam logic [7:0] OPT_SERVER_ID    = 8'd54;
   localparam logic [7:0] OPT_CLIENT_ID    = 8'd61;
   localparam logic [7:0] OPT_END          = 8'd255;

   // Option kind, worked out by the front end from the code byte.
   localparam logic [2:0] KIND_OTHER        = 3'd0;
   localparam logic [2:0] KIND_MESSAGE_TYPE = 3'd1;
   localparam logic [2:0] KIND_LEASE_TIME   = 3'd2;
   localparam logic [2:0] KIND_SERVER_ID    = 3'd3;
   localparam logic [2:0] KIND_CLIENT_ID    = 3'd4;

   // Result status codes.
   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_BAD_COOKIE  = 2'd1;
   localparam logic [1:0] STATUS_ID_MISMATCH = 2'd2;
   localparam logic [1:0] STATUS_NO_END      = 2'd3;

   // One classified byte as it travels through the queue.
   typedef struct packed {
      logic [7:0] option_byte;
      logic       last_byte;
      logic [2:0] kind;
      logic       is_pad;
      logic       is_end;
      logic [3:0] cookie_hit;
   } entry_type;

endpackage

/* rtl/core/dhcp_option_parser.sv */
// rsp_valid comes from the result register, which takes the result when the parser pops the queued item
// that carries last_byte, provided nothing is queued ahead of it and the result register is free.
// Throughput: one option byte per cycle, except that a last byte waits for a free result register.
// A four-entry queue parts the byte input from the parser, and a result register
// parts the parser from the result channel, so each side may stall on its own.
// Reset (synchronous, active high) empties queue and result register, clears the id registers.
// ----------------------------------------------------------------------------
// DHCP option parser
// Checks the magic cookie, walks the DHCP options and reports message type,
// lease time, server identifier and a client identifier check per packet.
// ----------------------------------------------------------------------------
module dhcp_option_parser #(
   parameter int CLIENT_ID_MAX_BYTES = dop_pkg::CLIENT_ID_MAX_BYTES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_option_byte,
   input  logic                              req_last_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_parse_status,
   output logic [7:0]                        rsp_message_type,
   output logic                              rsp_message_type_seen,
   output logic [31:0]                       rsp_lease_seconds,
   output logic                              rsp_lease_seen,
   output logic [31:0]                       rsp_server_address,
   output logic                              rsp_server_seen,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dop_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [dop_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int LEN_W = dop_pkg::ID_LENGTH_W;

   logic [LEN_W-1:0]                  id_length_ff, id_length_in;
   logic [CLIENT_ID_MAX_BYTES-1:0][7:0] id_bytes_ff, id_bytes_in;
   logic                              csr_write;
   dop_pkg::entry_type                q_entry;
   logic                              q_valid;
   logic                              q_pop;

   // Configuration registers: writes are always taken.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      id_length_in = id_length_ff;
      if (csr_write && csr_index == dop_pkg::CSR_CLIENT_ID_LENGTH) begin
         id_length_in = csr_data[LEN_W-1:0];
      end
   end

   // Each stored identifier byte is loaded from the low or high word.
   for (genvar i = 0; i < CLIENT_ID_MAX_BYTES; i++) begin : g_id_byte
      if (i < 8) begin : g_low
         assign id_bytes_in[i] = (csr_write && csr_index == dop_pkg::CSR_CLIENT_ID_LOW) ?
                                 csr_data[8*i +: 8] : id_bytes_ff[i];
      end else begin : g_high
         assign id_bytes_in[i] = (csr_write && csr_index == dop_pkg::CSR_CLIENT_ID_HIGH) ?
                                 csr_data[8*(i-8) +: 8] : id_bytes_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_length_ff <= '0;
         id_bytes_ff  <= '0;
      end else begin
         id_length_ff <= id_length_in;
         id_bytes_ff  <= id_bytes_in;
      end
   end

   // Front end: byte intake, classification and queue.
   dop_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_option_byte (req_option_byte),
      .req_last_byte   (req_last_byte),
      .q_entry         (q_entry),
      .q_valid         (q_valid),
      .q_pop           (q_pop)
   );

   // Back end: option walk and result register.
   dop_back #(
      .CLIENT_ID_MAX_BYTES (CLIENT_ID_MAX_BYTES)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .q_entry               (q_entry),
      .q_valid               (q_valid),
      .q_pop                 (q_pop),
      .id_length             (id_length_ff),
      .id_bytes              (id_bytes_ff),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_parse_status      (rsp_parse_status),
      .rsp_message_type      (rsp_message_type),
      .rsp_message_type_seen (rsp_message_type_seen),
      .rsp_lease_seconds     (rsp_lease_seconds),
      .rsp_lease_seen        (rsp_lease_seen),
      .rsp_server_address    (rsp_server_address),
      .rsp_server_seen       (rsp_server_seen)
   );

endmodule

/* rtl/core/dop_front.sv */
// ----------------------------------------------------------------------------
// DHCP option parser front end
// Accepts option bytes, classifies each one (cookie match, pad, end, option
// kind) and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module dop_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_option_byte,
   input  logic                req_last_byte,
   output dop_pkg::entry_type  q_entry,
   output logic                q_valid,
   input  logic                q_pop
);

   localparam int PTR_W = dop_pkg::QUEUE_PTR_W;
   localparam int CNT_W = dop_pkg::QUEUE_CNT_W;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(dop_pkg::QUEUE_DEPTH);

   dop_pkg::entry_type queue_ff [dop_pkg::QUEUE_DEPTH];
   dop_pkg::entry_type class_entry;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;

   // Classify the incoming byte.
   always_comb begin
      class_entry.option_byte = req_option_byte;
      class_entry.last_byte   = req_last_byte;
      class_entry.is_pad      = (req_option_byte == dop_pkg::OPT_PAD);
      class_entry.is_end      = (req_option_byte == dop_pkg::OPT_END);
      for (int i = 0; i < 4; i++) begin
         class_entry.cookie_hit[i] = (req_option_byte == dop_pkg::MAGIC_COOKIE[i]);
      end
      unique case (req_option_byte)
         dop_pkg::OPT_MESSAGE_TYPE: class_entry.kind = dop_pkg::KIND_MESSAGE_TYPE;
         dop_pkg::OPT_LEASE_TIME:   class_entry.kind = dop_pkg::KIND_LEASE_TIME;
         dop_pkg::OPT_SERVER_ID:    class_entry.kind = dop_pkg::KIND_SERVER_ID;
         dop_pkg::OPT_CLIENT_ID:    class_entry.kind = dop_pkg::KIND_CLIENT_ID;
         default:                   class_entry.kind = dop_pkg::KIND_OTHER;
      endcase
   end

   // Queue control: an item is taken whenever there is room.
   assign req_ready = (count_ff != DEPTH_CNT);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign q_entry   = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= class_entry;
      end
   end

   // The fill count never passes the depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("queue fill count above depth");

   // A push without a pop grows the fill count by exactly one.
   a_count_grow: assert property (@(posedge clock) disable iff (reset)
      (push && !q_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue fill count did not follow a push");

   // The back end only takes an item while the queue holds one.
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

endmodule

/* rtl/core/dop_back.sv */
// ----------------------------------------------------------------------------
// DHCP option parser back end
// Walks the cookie and the code/length/value options one queued byte per cycle
// (a last byte waits for a free result register), keeps the extracted values and registers one result per packet.
// ----------------------------------------------------------------------------
module dop_back #(
   parameter int CLIENT_ID_MAX_BYTES = dop_pkg::CLIENT_ID_MAX_BYTES
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  dop_pkg::entry_type                     q_entry,
   input  logic                                   q_valid,
   output logic                                   q_pop,
   input  logic [dop_pkg::ID_LENGTH_W-1:0]        id_length,
   input  logic [CLIENT_ID_MAX_BYTES-1:0][7:0]    id_bytes,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [1:0]                             rsp_parse_status,
   output logic [7:0]                             rsp_message_type,
   output logic                                   rsp_message_type_seen,
   output logic [31:0]                            rsp_lease_seconds,
   output logic                                   rsp_lease_seen,
   output logic [31:0]                            rsp_server_address,
   output logic                                   rsp_server_seen
);

   localparam int IDX_W = (CLIENT_ID_MAX_BYTES > 1) ? $clog2(CLIENT_ID_MAX_BYTES) : 1;
   localparam int LEN_W = dop_pkg::ID_LENGTH_W;

   // Parser phases.
   localparam logic [2:0] PH_COOKIE = 3'd0;
   localparam logic [2:0] PH_CODE   = 3'd1;
   localparam logic [2:0] PH_LEN    = 3'd2;
   localparam logic [2:0] PH_VALUE  = 3'd3;
   localparam logic [2:0] PH_DONE   = 3'd4;

   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  count_ff, count_in;
   logic [2:0]  kind_ff, kind_in;
   logic [7:0]  remain_ff, remain_in;
   logic [31:0] shift_ff, shift_in;
   logic [7:0]  msg_type_ff, msg_type_in;
   logic [31:0] lease_ff, lease_in;
   logic [31:0] server_ff, server_in;
   logic [2:0]  seen_ff, seen_in;
   logic [1:0]  stop_ff, stop_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [7:0]  rsp_msg_type_ff, rsp_msg_type_in;
   logic [31:0] rsp_lease_ff, rsp_lease_in;
   logic [31:0] rsp_server_ff, rsp_server_in;
   logic [2:0]  rsp_seen_ff, rsp_seen_in;

   logic [LEN_W-1:0] id_len_eff;
   logic [7:0]       id_ref;
   logic [7:0]       b;
   logic [7:0]       count_next;
   logic [31:0]      shift_next;
   logic [7:0]       remain_next;

   assign b = q_entry.option_byte;

   // Effective identifier length and the identifier byte at the current place.
   always_comb begin
      id_len_eff = (id_length > LEN_W'(CLIENT_ID_MAX_BYTES)) ?
                   LEN_W'(CLIENT_ID_MAX_BYTES) : id_length;
      id_ref = (count_ff < 8'(CLIENT_ID_MAX_BYTES)) ? id_bytes[count_ff[IDX_W-1:0]] : 8'd0;
   end

   // A result item needs a free output register; other items pass freely.
   assign q_pop = q_valid && (!q_entry.last_byte || !rsp_valid_ff || rsp_ready);

   // Value phase arithmetic.
   always_comb begin
      count_next  = count_ff + 8'd1;
      remain_next = remain_ff - 8'd1;
      shift_next  = (count_ff < 8'd4) ? {shift_ff[23:0], b} : shift_ff;
   end

   // Parser step and result capture.
   always_comb begin
      phase_in        = phase_ff;
      count_in        = count_ff;
      kind_in         = kind_ff;
      remain_in       = remain_ff;
      shift_in        = shift_ff;
      msg_type_in     = msg_type_ff;
      lease_in        = lease_ff;
      server_in       = server_ff;
      seen_in         = seen_ff;
      stop_in         = stop_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_status_in   = rsp_status_ff;
      rsp_msg_type_in = rsp_msg_type_ff;
      rsp_lease_in    = rsp_lease_ff;
      rsp_server_in   = rsp_server_ff;
      rsp_seen_in     = rsp_seen_ff;

      if (q_pop) begin
         unique case (phase_ff)
            PH_COOKIE: begin
               if (!q_entry.cookie_hit[count_ff[1:0]]) begin
                  phase_in = PH_DONE;
                  stop_in  = dop_pkg::STATUS_BAD_COOKIE;
               end else if (count_ff >= 8'd3) begin
                  count_in = 8'd0;
                  phase_in = PH_CODE;
               end else begin
                  count_in = count_next;
               end
            end
            PH_CODE: begin
               if (q_entry.is_end) begin
                  phase_in = PH_DONE;
                  stop_in  = dop_pkg::STATUS_OK;
               end else if (!q_entry.is_pad) begin
                  kind_in  = q_entry.kind;
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               remain_in = b;
               count_in  = 8'd0;
               shift_in  = 32'd0;
               if (kind_ff == dop_pkg::KIND_CLIENT_ID && b > 8'(id_len_eff)) begin
                  phase_in = PH_DONE;
                  stop_in  = dop_pkg::STATUS_ID_MISMATCH;
               end else if (b == 8'd0) begin
                  // An empty option completes with nothing recorded.
                  phase_in = PH_CODE;
               end else begin
                  phase_in = PH_VALUE;
               end
            end
            PH_VALUE: begin
               if (kind_ff == dop_pkg::KIND_CLIENT_ID && b != id_ref) begin
                  phase_in = PH_DONE;
                  stop_in  = dop_pkg::STATUS_ID_MISMATCH;
               end else begin
                  shift_in  = shift_next;
                  count_in  = count_next;
                  remain_in = remain_next;
                  if (remain_next == 8'd0) begin
                     // Option complete: record its value if it is long enough.
                     phase_in = PH_CODE;
                     if (kind_ff == dop_pkg::KIND_MESSAGE_TYPE) begin
                        case (count_next)
                           8'd1:    msg_type_in = shift_next[7:0];
                           8'd2:    msg_type_in = shift_next[15:8];
                           8'd3:    msg_type_in = shift_next[23:16];
                           default: msg_type_in = shift_next[31:24];
                        endcase
                        seen_in[0] = 1'b1;
                     end else if (kind_ff == dop_pkg::KIND_LEASE_TIME &&
                                  count_next >= 8'd4) begin
                        lease_in   = shift_next;
                        seen_in[1] = 1'b1;
                     end else if (kind_ff == dop_pkg::KIND_SERVER_ID &&
                                  count_next >= 8'd4) begin
                        server_in  = shift_next;
                        seen_in[2] = 1'b1;
                     end
                  end
               end
            end
            default: begin
               // Stopped: bytes are ignored until the packet ends.
            end
         endcase

         // The last byte of a packet produces the result and clears the parser.
         if (q_entry.last_byte) begin
            rsp_valid_in = 1'b1;
            if (phase_in == PH_DONE) begin
               rsp_status_in = stop_in;
            end else if (phase_in == PH_COOKIE) begin
               rsp_status_in = dop_pkg::STATUS_BAD_COOKIE;
            end else begin
               rsp_status_in = dop_pkg::STATUS_NO_END;
            end
            rsp_msg_type_in = msg_type_in;
            rsp_lease_in    = lease_in;
            rsp_server_in   = server_in;
            rsp_seen_in     = seen_in;
            phase_in    = PH_COOKIE;
            count_in    = 8'd0;
            kind_in     = dop_pkg::KIND_OTHER;
            remain_in   = 8'd0;
            shift_in    = 32'd0;
            msg_type_in = 8'd0;
            lease_in    = 32'd0;
            server_in   = 32'd0;
            seen_in     = 3'd0;
            stop_in     = dop_pkg::STATUS_OK;
         end
      end
   end

   // Parser state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_COOKIE;
         count_ff    <= 8'd0;
         kind_ff     <= dop_pkg::KIND_OTHER;
         remain_ff   <= 8'd0;
         shift_ff    <= 32'd0;
         msg_type_ff <= 8'd0;
         lease_ff    <= 32'd0;
         server_ff   <= 32'd0;
         seen_ff     <= 3'd0;
         stop_ff     <= dop_pkg::STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         kind_ff     <= kind_in;
         remain_ff   <= remain_in;
         shift_ff    <= shift_in;
         msg_type_ff <= msg_type_in;
         lease_ff    <= lease_in;
         server_ff   <= server_in;
         seen_ff     <= seen_in;
         stop_ff     <= stop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      rsp_status_ff   <= rsp_status_in;
      rsp_msg_type_ff <= rsp_msg_type_in;
      rsp_lease_ff    <= rsp_lease_in;
      rsp_server_ff   <= rsp_server_in;
      rsp_seen_ff     <= rsp_seen_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_parse_status      = rsp_status_ff;
   assign rsp_message_type      = rsp_msg_type_ff;
   assign rsp_message_type_seen = rsp_seen_ff[0];
   assign rsp_lease_seconds     = rsp_lease_ff;
   assign rsp_lease_seen        = rsp_seen_ff[1];
   assign rsp_server_address    = rsp_server_ff;
   assign rsp_server_seen       = rsp_seen_ff[2];

   // A result appears only after the last byte of a packet was taken.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(q_pop && q_entry.last_byte))
      else $error("result raised without a last byte");

   // After a packet ends the parser is back at the cookie with nothing held.
   a_packet_clear: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_entry.last_byte) |=> (phase_ff == PH_COOKIE && seen_ff == 3'd0))
      else $error("parser not cleared after packet end");

   // The phase register only holds defined phases.
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PH_DONE)
      else $error("parser phase out of range");

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// DHCP option parser testbench
// Sends whole option areas one byte per item and predicts the single report
// of each area with a parser model kept in the bench. Directed areas cover
// the cookie, each value option, truncation and the client identifier check.
// Random areas follow under changing identifiers and idle patterns, with one
// long stall on the result side.
// ----------------------------------------------------------------------------
module testbench;

   localparam int WATCHDOG_CYCLES = 2000;
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_CYCLES = 80;
   localparam logic [dop_pkg::CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 2'd3;

   typedef enum logic [2:0] {
      AWAIT_COOKIE, AWAIT_CODE, AWAIT_LENGTH, IN_VALUE, STOPPED
   } parse_phase_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  message_type;
      logic        type_seen;
      logic [31:0] lease;
      logic        lease_seen;
      logic [31:0] server;
      logic        server_seen;
   } packet_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_option_byte = 8'd0;
   logic req_last_byte = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_parse_status;
   logic [7:0] rsp_message_type;
   logic rsp_message_type_seen;
   logic [31:0] rsp_lease_seconds;
   logic rsp_lease_seen;
   logic [31:0] rsp_server_address;
   logic rsp_server_seen;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [dop_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [dop_pkg::CSR_DATA_W-1:0] csr_data = '0;

   // Client identifier as the bench believes it is programmed.
   logic [4:0] id_length = 5'd0;
   logic [63:0] id_low = 64'd0;
   logic [63:0] id_high = 64'd0;

   // Parser state of the bench model.
   parse_phase_type phase;
   logic [7:0] byte_count;
   logic [7:0] option_code;
   logic [7:0] value_left;
   logic [31:0] value_acc;
   logic [7:0] held_type;
   logic [31:0] held_lease;
   logic [31:0] held_server;
   logic [2:0] seen;
   logic [1:0] stop_code;

   packet_report_type pending_reports[$];
   packet_report_type oldest_report;
   logic [7:0] pkt[$];
   int pkt_ignored = 0;

   int send_idle_pct = 14;
   int recv_idle_pct = 65;
   bit hold_request = 1'b0;
   int hold_left = 0;
   int stalled_cycles = 0;
   int error_count = 0;
   int packets_sent = 0;
   int live_items = 0;
   int settings_count = 0;
   int status_tally[4] = '{0, 0, 0, 0};

   dhcp_option_parser dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Parser model
   // ------------------------------------------------------------------------

   function automatic void clear_parser();
      phase = AWAIT_COOKIE;
      byte_count = 8'd0;
      option_code = 8'd0;
      value_left = 8'd0;
      value_acc = 32'd0;
      held_type = 8'd0;
      held_lease = 32'd0;
      held_server = 32'd0;
      seen = 3'd0;
      stop_code = dop_pkg::STATUS_OK;
   endfunction

   function automatic void halt_parse(input logic [1:0] code);
      phase = STOPPED;
      stop_code = code;
   endfunction

   // A value counts only once its option is complete and long enough.
   function automatic void close_option();
      int unsigned k;
      k = (byte_count > 8'd4) ? 4 : byte_count;
      if (option_code == dop_pkg::OPT_MESSAGE_TYPE && byte_count >= 8'd1) begin
         held_type = value_acc[8*(k-1) +: 8];
         seen[0] = 1'b1;
      end else if (option_code == dop_pkg::OPT_LEASE_TIME && byte_count >= 8'd4) begin
         held_lease = value_acc;
         seen[1] = 1'b1;
      end else if (option_code == dop_pkg::OPT_SERVER_ID && byte_count >= 8'd4) begin
         held_server = value_acc;
         seen[2] = 1'b1;
      end
      phase = AWAIT_CODE;
   endfunction

   // Steps the model by one option byte; returns 1 with the report on the last byte.
   function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                     output packet_report_type rep);
      logic [127:0] id_bytes;
      logic [4:0] eff_len;
      id_bytes = {id_high, id_low};
      eff_len = (id_length > 5'(dop_pkg::CLIENT_ID_MAX_BYTES)) ?
                5'(dop_pkg::CLIENT_ID_MAX_BYTES) : id_length;
      rep = '0;
      case (phase)
         AWAIT_COOKIE: begin
            if (b != dop_pkg::MAGIC_COOKIE[byte_count[1:0]]) begin
               halt_parse(dop_pkg::STATUS_BAD_COOKIE);
            end else begin
               byte_count = byte_count + 8'd1;
               if (byte_count >= 8'd4) begin
                  byte_count = 8'd0;
                  phase = AWAIT_CODE;
               end
            end
         end
         AWAIT_CODE: begin
            if (b == dop_pkg::OPT_END) begin
               halt_parse(dop_pkg::STATUS_OK);
            end else if (b != dop_pkg::OPT_PAD) begin
               option_code = b;
               phase = AWAIT_LENGTH;
            end
         end
         AWAIT_LENGTH: begin
            value_left = b;
            byte_count = 8'd0;
            value_acc = 32'd0;
            if (option_code == dop_pkg::OPT_CLIENT_ID && b > 8'(eff_len))
               halt_parse(dop_pkg::STATUS_ID_MISMATCH);
            else if (b == 8'd0) close_option();
            else phase = IN_VALUE;
         end
         IN_VALUE: begin
            if (option_code == dop_pkg::OPT_CLIENT_ID &&
                b != id_bytes[8*int'(byte_count) +: 8]) begin
               halt_parse(dop_pkg::STATUS_ID_MISMATCH);
            end else begin
               if (byte_count < 8'd4) value_acc = {value_acc[23:0], b};
               byte_count = byte_count + 8'd1;
               value_left = value_left - 8'd1;
               if (value_left == 8'd0) close_option();
            end
         end
         default: begin
         end
      endcase
      if (!last) return 1'b0;
      if (phase == STOPPED) rep.status = stop_code;
      else if (phase == AWAIT_COOKIE) rep.status = dop_pkg::STATUS_BAD_COOKIE;
      else rep.status = dop_pkg::STATUS_NO_END;
      rep.message_type = held_type;
      rep.type_seen = seen[0];
      rep.lease = held_lease;
      rep.lease_seen = seen[1];
      rep.server = held_server;
      rep.server_seen = seen[2];
      clear_parser();
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------------
   // Option area building
   // ------------------------------------------------------------------------

   function automatic void begin_packet();
      int i;
      pkt.delete();
      pkt_ignored = 0;
      for (i = 0; i < 4; i++) pkt.push_back(dop_pkg::MAGIC_COOKIE[i]);
   endfunction

   // The first four value bytes come from value, most significant first.
   function automatic void add_option(input logic [7:0] code, input int len,
                                      input logic [31:0] value);
      int i;
      pkt.push_back(code);
      pkt.push_back(8'(len));
      for (i = 0; i < len; i++) pkt.push_back((i < 4) ? value[31-8*i -: 8] : 8'($urandom));
   endfunction

   // Client identifier option copied from the programmed bytes, one byte spoilt if asked.
   function automatic void add_client_id(input int len, input int spoilt);
      logic [127:0] id_bytes;
      logic [7:0] b;
      int i;
      id_bytes = {id_high, id_low};
      pkt.push_back(dop_pkg::OPT_CLIENT_ID);
      pkt.push_back(8'(len));
      for (i = 0; i < len; i++) begin
         b = (i < 16) ? id_bytes[8*i +: 8] : 8'($urandom);
         if (i == spoilt) b = b ^ 8'($urandom_range(1, 255));
         pkt.push_back(b);
      end
   endfunction

   // Mostly well-formed areas with random options, some broken, some noise.
   function automatic void make_random_packet();
      int unsigned choice, r, eff, len, cut;
      begin_packet();
      choice = $urandom_range(0, 99);
      if (choice < 6) begin
         pkt.delete();
         repeat ($urandom_range(1, 10)) pkt.push_back(8'($urandom));
         return;
      end
      if (choice < 14) pkt[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
      eff = (id_length > 5'd16) ? 16 : id_length;
      repeat ($urandom_range(0, 6)) begin
         r = $urandom_range(0, 99);
         if (r < 10) begin
            pkt.push_back(dop_pkg::OPT_PAD);
         end else if (r < 25) begin
            add_option(dop_pkg::OPT_MESSAGE_TYPE, $urandom_range(0, 3), $urandom);
         end else if (r < 40) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : 4;
            add_option(dop_pkg::OPT_LEASE_TIME, len, $urandom);
         end else if (r < 55) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : 4;
            add_option(dop_pkg::OPT_SERVER_ID, len, $urandom);
         end else if (r < 70) begin
            if ($urandom_range(0, 7) == 0) begin
               add_client_id(eff + $urandom_range(1, 3), -1);
            end else begin
               len = $urandom_range(0, eff);
               if (len > 0 && $urandom_range(0, 5) == 0)
                  add_client_id(len, $urandom_range(0, len - 1));
               else
                  add_client_id(len, -1);
            end
         end else begin
            add_option(8'($urandom_range(1, 254)), $urandom_range(0, 8), $urandom);
         end
      end
      r = $urandom_range(0, 99);
      if (r < 78) begin
         pkt.push_back(dop_pkg::OPT_END);
         pkt_ignored = $urandom_range(0, 2);
         repeat (pkt_ignored) pkt.push_back(8'($urandom));
      end else if (r >= 88) begin
         cut = $urandom_range(1, pkt.size());
         while (pkt.size() > cut) void'(pkt.pop_back());
      end
   endfunction

   // ------------------------------------------------------------------------
   // Driving
   // ------------------------------------------------------------------------

   task automatic send_byte(input logic [7:0] value, input logic last);
      packet_report_type rep;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_option_byte <= value;
      req_last_byte <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (parse_byte(value, last, rep)) pending_reports.push_back(rep);
   endtask

   task automatic send_packet();
      int i;
      for (i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
      packets_sent++;
      live_items += pkt.size() - pkt_ignored;
   endtask

   // Waits until every report is in and the pipeline has gone quiet.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [dop_pkg::CSR_INDEX_W-1:0] idx,
                                 input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         dop_pkg::CSR_CLIENT_ID_LENGTH: id_length = value[4:0];
         dop_pkg::CSR_CLIENT_ID_LOW: id_low = value;
         dop_pkg::CSR_CLIENT_ID_HIGH: id_high = value;
         default: begin
         end
      endcase
   endtask

   task automatic set_client_id(input logic [4:0] len, input logic [63:0] low,
                                input logic [63:0] high);
      settle();
      write_register(dop_pkg::CSR_CLIENT_ID_LENGTH, 64'(len));
      write_register(dop_pkg::CSR_CLIENT_ID_LOW, low);
      write_register(dop_pkg::CSR_CLIENT_ID_HIGH, high);
      csr_valid <= 1'b0;
      settings_count++;
   endtask

   // ------------------------------------------------------------------------
   // Result side: random stalls, with an occasional long hold-off.
   // ------------------------------------------------------------------------

   always @(posedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------

   task automatic report_error(input string msg);
      error_count++;
      $display("ERROR %0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_error($sformatf("%s is %0h, %0h expected", name, got, want));
   endtask

   // Each report is compared with the oldest one predicted.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            report_error("report with no option area outstanding");
         end else begin
            oldest_report = pending_reports.pop_front();
            status_tally[oldest_report.status]++;
            check_field("parse status", 32'(rsp_parse_status), 32'(oldest_report.status));
            check_field("message type", 32'(rsp_message_type),
                        32'(oldest_report.message_type));
            check_field("message type flag", 32'(rsp_message_type_seen),
                        32'(oldest_report.type_seen));
            check_field("lease", rsp_lease_seconds, oldest_report.lease);
            check_field("lease flag", 32'(rsp_lease_seen), 32'(oldest_report.lease_seen));
            check_field("server", rsp_server_address, oldest_report.server);
            check_field("server flag", 32'(rsp_server_seen), 32'(oldest_report.server_seen));
         end
      end
   end

   // The run is abandoned if no handshake of any kind happens for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready))
         stalled_cycles <= 0;
      else
         stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= WATCHDOG_CYCLES) begin
         $display("Watchdog: no handshake for %0d cycles", stalled_cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   task automatic test_cookie();
      int pos;
      // Smallest good area: the cookie and the end option.
      begin_packet();
      pkt.push_back(dop_pkg::OPT_END);
      send_packet();
      // A wrong byte in each cookie position; what follows is ignored.
      for (pos = 0; pos < 4; pos++) begin
         begin_packet();
         pkt[pos] = ~pkt[pos];
         add_option(dop_pkg::OPT_MESSAGE_TYPE, 1, 32'hFF00_0000);
         pkt.push_back(dop_pkg::OPT_END);
         send_packet();
      end
      // Areas that end inside the cookie.
      begin_packet();
      void'(pkt.pop_back());
      void'(pkt.pop_back());
      send_packet();
      pkt.delete();
      pkt.push_back(dop_pkg::MAGIC_COOKIE[0]);
      send_packet();
      settle();
   endtask

   task automatic test_value_options();
      // Extreme values, pads and bytes after the end option.
      begin_packet();
      pkt.push_back(dop_pkg::OPT_PAD);
      add_option(dop_pkg::OPT_MESSAGE_TYPE, 1, 32'h0000_0000);
      pkt.push_back(dop_pkg::OPT_PAD);
      add_option(dop_pkg::OPT_LEASE_TIME, 4, 32'hFFFF_FFFF);
      add_option(dop_pkg::OPT_SERVER_ID, 4, 32'h0000_0000);
      pkt.push_back(dop_pkg::OPT_END);
      pkt.push_back(8'hFF);
      pkt.push_back(8'h00);
      pkt_ignored = 2;
      send_packet();
      // Long options, and later options of the same code overwriting earlier ones.
      begin_packet();
      add_option(dop_pkg::OPT_MESSAGE_TYPE, 3, 32'hFF01_0200);
      add_option(dop_pkg::OPT_LEASE_TIME, 6, 32'h0000_0001);
      add_option(dop_pkg::OPT_SERVER_ID, 4, 32'hFFFF_FFFF);
      add_option(dop_pkg::OPT_LEASE_TIME, 4, 32'h1234_5678);
      add_option(dop_pkg::OPT_MESSAGE_TYPE, 1, 32'h0200_0000);
      pkt.push_back(dop_pkg::OPT_END);
      send_packet();
      // Options too short to count, and one unknown option of the largest length.
      begin_packet();
      add_option(dop_pkg::OPT_MESSAGE_TYPE, 0, 32'h0);
      add_option(dop_pkg::OPT_LEASE_TIME, 3, 32'hAABB_CCDD);
      add_option(dop_pkg::OPT_SERVER_ID, 0, 32'h0);
      add_option(8'd200, 0, 32'h0);
      add_option(8'd1, 255, $urandom);
      pkt.push_back(dop_pkg::OPT_END);
      send_packet();
      // An option after the end option is not parsed.
      begin_packet();
      pkt.push_back(dop_pkg::OPT_END);
      add_option(dop_pkg::OPT_LEASE_TIME, 4, 32'h0102_0304);
      send_packet();
      settle();
   endtask

   task automatic test_truncation();
      // Area ends inside a lease option: the earlier message type still counts.
      begin_packet();
      add_option(dop_pkg::OPT_MESSAGE_TYPE, 1, 32'h0700_0000);
      pkt.push_back(dop_pkg::OPT_LEASE_TIME);
      pkt.push_back(8'd4);
      pkt.push_back(8'hAA);
      pkt.push_back(8'hBB);
      send_packet();
      // Complete options but no end option.
      begin_packet();
      add_option(dop_pkg::OPT_SERVER_ID, 4, 32'h0A00_0001);
      send_packet();
      // Area ends right after an option code.
      begin_packet();
      pkt.push_back(dop_pkg::OPT_PAD);
      pkt.push_back(dop_pkg::OPT_LEASE_TIME);
      send_packet();
      settle();
   endtask

   task automatic test_client_id();
      // Reset identifier is empty: only a zero length matches.
      begin_packet();
      add_client_id(0, -1);
      pkt.push_back(dop_pkg::OPT_END);
      send_packet();
      begin_packet();
      add_option(dop_pkg::OPT_MESSAGE_TYPE, 1, 32'h0500_0000);
      add_client_id(1, -1);
      pkt.push_back(dop_pkg::OPT_END);
      send_packet();
      // Full sixteen-byte identifier: exact, spoilt last byte, one too long.
      set_client_id(5'd16, '1, {$urandom, $urandom});
      begin_packet();
      add_client_id(16, -1);
      pkt.push_back(dop_pkg::OPT_END);
      send_packet();
      begin_packet();
      add_option(dop_pkg::OPT_SERVER_ID, 4, 32'hC0A8_0001);
      add_client_id(16, 15);
      pkt.push_back(dop_pkg::OPT_END);
      send_packet();
      begin_packet();
      add_client_id(17, -1);
      pkt.push_back(dop_pkg::OPT_END);
      send_packet();
      // Length register above the maximum acts as sixteen; prefixes match.
      set_client_id(5'd31, '0, 64'h0123_4567_89AB_CDEF);
      begin_packet();
      add_client_id(16, -1);
      add_client_id(5, -1);
      add_client_id(0, -1);
      pkt.push_back(dop_pkg::OPT_END);
      send_packet();
      // A write to the spare index must leave the identifier alone.
      settle();
      write_register(CSR_SPARE_INDEX, '1);
      csr_valid <= 1'b0;
      begin_packet();
      add_client_id(17, -1);
      pkt.push_back(dop_pkg::OPT_END);
      send_packet();
      settle();
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct, input int budget);
      int start;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      start = live_items;
      while (live_items - start < budget) begin
         make_random_packet();
         send_packet();
      end
      settle();
   endtask

   // The result side holds off while bytes keep coming, so the input backs up.
   task automatic test_backpressure();
      int start;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request = 1'b1;
      start = live_items;
      while (live_items - start < 150) begin
         make_random_packet();
         send_packet();
      end
      settle();
   endtask

   initial begin
      clear_parser();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_cookie();
      test_value_options();
      test_truncation();
      test_client_id();
      set_client_id(5'($urandom_range(0, 16)), {$urandom, $urandom}, {$urandom, $urandom});
      test_random_traffic(14, 65, 420);
      set_client_id(5'd31, '1, '0);
      test_random_traffic(65, 14, 420);
      set_client_id(5'($urandom_range(0, 31)), {$urandom, $urandom}, {$urandom, $urandom});
      test_backpressure();
      test_random_traffic(0, 0, 250);
      if (pending_reports.size() != 0) report_error("reports still outstanding at the end");
      $display("Sent %0d option areas (%0d parsed bytes) under %0d identifier settings.",
               packets_sent, live_items, settings_count + 1);
      $display("Reports: %0d ended, %0d bad cookie, %0d id mismatch, %0d no end option.",
               status_tally[0], status_tally[1], status_tally[2], status_tally[3]);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
